>>> hw/rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// shared types and constants for the closest point on segment pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 32;
   localparam int unsigned FRAC_BITS_DEFAULT  = 16;
   localparam int unsigned IO_BITS            = 32;
   localparam int unsigned DIST_BITS          = 64;
   localparam int unsigned T_BITS             = 32;

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

endpackage

`default_nettype wire

>>> hw/rtl/cps_divider.sv
// ----------------------------------------------------------------------------
// cps_divider
// pipelined restoring divider, one quotient bit per stage, with a sideband
// ----------------------------------------------------------------------------
`default_nettype none

module cps_divider
   import cps_pkg::*;
#(
   parameter int unsigned NUM_BITS = 67,
   parameter int unsigned QUO_BITS = 32,
   parameter int unsigned SIDE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire logic [NUM_BITS-1:0]  in_num,
   input  wire logic [NUM_BITS-1:0]  in_den,
   input  wire logic [SIDE_BITS-1:0] in_side,
   output logic                      out_valid,
   output logic [QUO_BITS-1:0]       out_quo,
   output logic [SIDE_BITS-1:0]      out_side
);

   logic [QUO_BITS-1:0]              valid_ff;
   logic [NUM_BITS-1:0]              rem_ff  [QUO_BITS];
   logic [NUM_BITS-1:0]              den_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]              quo_ff  [QUO_BITS];
   logic [SIDE_BITS-1:0]             side_ff [QUO_BITS];

   // remainder stays below the divisor, so one extra bit holds the shift
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
      logic                 src_valid;
      logic [NUM_BITS-1:0]  src_rem;
      logic [NUM_BITS-1:0]  src_den;
      logic [QUO_BITS-1:0]  src_quo;
      logic [SIDE_BITS-1:0] src_side;
      logic [NUM_BITS:0]    shifted_in;
      logic                 take_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_den   = den_ff[i-1];
         assign src_quo   = quo_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      always_comb begin
         shifted_in = {src_rem, 1'b0};
         take_in    = shifted_in >= {1'b0, src_den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= src_valid;
         end
         if (enable) begin
            rem_ff[i]  <= take_in ? NUM_BITS'(shifted_in - {1'b0, src_den})
                                  : NUM_BITS'(shifted_in);
            den_ff[i]  <= src_den;
            quo_ff[i]  <= {src_quo[QUO_BITS-2:0], take_in};
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

`default_nettype wire

>>> hw/rtl/closest_point_on_segment_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment_top
// closest point on a 2-d segment with squared distance and region code
// ----------------------------------------------------------------------------
// One transaction enters per cycle and one result leaves per cycle while the
// result side is not stalled. The pipeline has 3 stages of differences,
// products and the region decision, 32 stages of the bit-per-stage divider
// that forms the fraction t, 2 stages of interpolation and 3 stages of
// squared distance, the last of which is the output register. The whole
// pipeline advances only while its last stage is empty or being taken, so
// a stall on the result side holds every item in place.
`default_nettype none

module closest_point_on_segment_top
   import cps_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic signed [IO_BITS-1:0] req_query_x,
   input  wire logic signed [IO_BITS-1:0] req_query_y,
   input  wire logic signed [IO_BITS-1:0] req_start_x,
   input  wire logic signed [IO_BITS-1:0] req_start_y,
   input  wire logic signed [IO_BITS-1:0] req_end_x,
   input  wire logic signed [IO_BITS-1:0] req_end_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [IO_BITS-1:0]  rsp_nearest_x,
   output logic signed [IO_BITS-1:0]  rsp_nearest_y,
   output logic [DIST_BITS-1:0]       rsp_dist_squared,
   output logic [1:0]                 rsp_region
);

   localparam int unsigned CB = COORD_BITS;
   localparam int unsigned DB = CB + 1;          // difference width
   localparam int unsigned PB = 2 * DB;          // product width
   localparam int unsigned SB = PB + 1;          // sum of two products
   localparam int signed   SH = 32 - 2 * int'(FRAC_BITS);
   localparam int unsigned ST = 4 * CB + 4 * DB + 2; // divider sideband

   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // ---- stage 1: sign extend and differences
   logic                 v1_ff;
   logic signed [DB-1:0] qx1_ff, qy1_ff, sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic signed [DB-1:0] abx1_ff, aby1_ff, apx1_ff, apy1_ff;
   logic signed [DB-1:0] qx_in, qy_in, sx_in, sy_in, ex_in, ey_in;

   always_comb begin
      qx_in = DB'(signed'(req_query_x[CB-1:0]));
      qy_in = DB'(signed'(req_query_y[CB-1:0]));
      sx_in = DB'(signed'(req_start_x[CB-1:0]));
      sy_in = DB'(signed'(req_start_y[CB-1:0]));
      ex_in = DB'(signed'(req_end_x[CB-1:0]));
      ey_in = DB'(signed'(req_end_y[CB-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_valid;
      end
      if (enable) begin
         qx1_ff  <= qx_in;
         qy1_ff  <= qy_in;
         sx1_ff  <= sx_in;
         sy1_ff  <= sy_in;
         ex1_ff  <= ex_in;
         ey1_ff  <= ey_in;
         abx1_ff <= ex_in - sx_in;
         aby1_ff <= ey_in - sy_in;
         apx1_ff <= qx_in - sx_in;
         apy1_ff <= qy_in - sy_in;
      end
   end

   // ---- stage 2: four products
   logic                 v2_ff;
   logic signed [PB-1:0] d0_ff, d1_ff, l0_ff, l1_ff;
   logic signed [DB-1:0] sx2_ff, sy2_ff, ex2_ff, ey2_ff, qx2_ff, qy2_ff;
   logic signed [DB-1:0] abx2_ff, aby2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
      if (enable) begin
         d0_ff   <= apx1_ff * abx1_ff;
         d1_ff   <= apy1_ff * aby1_ff;
         l0_ff   <= abx1_ff * abx1_ff;
         l1_ff   <= aby1_ff * aby1_ff;
         sx2_ff  <= sx1_ff;
         sy2_ff  <= sy1_ff;
         ex2_ff  <= ex1_ff;
         ey2_ff  <= ey1_ff;
         qx2_ff  <= qx1_ff;
         qy2_ff  <= qy1_ff;
         abx2_ff <= abx1_ff;
         aby2_ff <= aby1_ff;
      end
   end

   // ---- stage 3: dot, length squared, region decision
   logic                 v3_ff;
   logic signed [SB-1:0] dot3_ff;
   logic        [SB-1:0] len3_ff;
   logic signed [SB-1:0] dot_in, len_in;
   logic [1:0]           reg3_ff;
   logic [1:0]           reg_in;
   logic signed [DB-1:0] sx3_ff, sy3_ff, ex3_ff, ey3_ff, qx3_ff, qy3_ff;
   logic signed [DB-1:0] abx3_ff, aby3_ff;

   always_comb begin
      dot_in = SB'(d0_ff) + SB'(d1_ff);
      len_in = SB'(l0_ff) + SB'(l1_ff);
      if (len_in == '0 || dot_in <= 0) begin
         reg_in = REGION_START;
      end else if (dot_in >= len_in) begin
         reg_in = REGION_END;
      end else begin
         reg_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
      if (enable) begin
         dot3_ff <= dot_in;
         len3_ff <= len_in;
         reg3_ff <= reg_in;
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ex3_ff  <= ex2_ff;
         ey3_ff  <= ey2_ff;
         qx3_ff  <= qx2_ff;
         qy3_ff  <= qy2_ff;
         abx3_ff <= abx2_ff;
         aby3_ff <= aby2_ff;
      end
   end

   // ---- divider: t = floor(dot * 2^32 / len); only interior items matter,
   // others divide zero so the remainder stays in range
   logic [SB-1:0] num_in;
   logic [ST-1:0] side_in, side_out;
   logic          v4;
   logic [T_BITS-1:0] t4;

   assign num_in  = (reg3_ff == REGION_INTERIOR) ? dot3_ff : '0;
   assign side_in = {reg3_ff, sx3_ff[CB-1:0], sy3_ff[CB-1:0], ex3_ff[CB-1:0],
                     ey3_ff[CB-1:0], abx3_ff, aby3_ff, qx3_ff, qy3_ff};

   cps_divider #(
      .NUM_BITS (SB),
      .QUO_BITS (T_BITS),
      .SIDE_BITS(ST)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (v3_ff),
      .in_num   (num_in),
      .in_den   (len3_ff),
      .in_side  (side_in),
      .out_valid(v4),
      .out_quo  (t4),
      .out_side (side_out)
   );

   logic [1:0]           reg4;
   logic signed [CB-1:0] sx4, sy4, ex4, ey4;
   logic signed [DB-1:0] abx4, aby4, qx4, qy4;
   assign {reg4, sx4, sy4, ex4, ey4, abx4, aby4, qx4, qy4} = side_out;

   // ---- stage 5: magnitude times t (one 33x32 product per coordinate)
   localparam int unsigned MB = DB + T_BITS;
   logic          v5_ff;
   logic [MB-1:0] px5_ff, py5_ff;
   logic          nx5_ff, ny5_ff;
   logic [1:0]    reg5_ff;
   logic signed [CB-1:0] sx5_ff, sy5_ff, ex5_ff, ey5_ff;
   logic signed [DB-1:0] qx5_ff, qy5_ff;
   logic [DB-1:0] magx_in, magy_in;

   assign magx_in = abx4[DB-1] ? DB'(-abx4) : DB'(abx4);
   assign magy_in = aby4[DB-1] ? DB'(-aby4) : DB'(aby4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (enable) begin
         v5_ff <= v4;
      end
      if (enable) begin
         px5_ff  <= MB'(magx_in) * MB'(t4);
         py5_ff  <= MB'(magy_in) * MB'(t4);
         nx5_ff  <= abx4[DB-1];
         ny5_ff  <= aby4[DB-1];
         reg5_ff <= reg4;
         sx5_ff  <= sx4;
         sy5_ff  <= sy4;
         ex5_ff  <= ex4;
         ey5_ff  <= ey4;
         qx5_ff  <= qx4;
         qy5_ff  <= qy4;
      end
   end

   // ---- stage 6: nearest point selection, toward minus infinity
   logic          v6_ff;
   logic signed [CB-1:0] nxp6_ff, nyp6_ff;
   logic [1:0]    reg6_ff;
   logic signed [DB-1:0] qx6_ff, qy6_ff;
   logic [DB-1:0] offx_in, offy_in;
   logic signed [CB-1:0] nx_in, ny_in;

   always_comb begin
      offx_in = nx5_ff ? DB'((px5_ff + MB'(33'h0_FFFF_FFFF)) >> T_BITS)
                       : DB'(px5_ff >> T_BITS);
      offy_in = ny5_ff ? DB'((py5_ff + MB'(33'h0_FFFF_FFFF)) >> T_BITS)
                       : DB'(py5_ff >> T_BITS);
      case (reg5_ff)
         REGION_END: begin
            nx_in = ex5_ff;
            ny_in = ey5_ff;
         end
         REGION_INTERIOR: begin
            nx_in = nx5_ff ? CB'(sx5_ff - CB'(offx_in)) : CB'(sx5_ff + CB'(offx_in));
            ny_in = ny5_ff ? CB'(sy5_ff - CB'(offy_in)) : CB'(sy5_ff + CB'(offy_in));
         end
         default: begin
            nx_in = sx5_ff;
            ny_in = sy5_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (enable) begin
         v6_ff <= v5_ff;
      end
      if (enable) begin
         nxp6_ff <= nx_in;
         nyp6_ff <= ny_in;
         reg6_ff <= reg5_ff;
         qx6_ff  <= qx5_ff;
         qy6_ff  <= qy5_ff;
      end
   end

   // ---- stage 7: offsets to the nearest point, magnitudes
   logic          v7_ff;
   logic [DB-1:0] mdx7_ff, mdy7_ff;
   logic signed [CB-1:0] nxp7_ff, nyp7_ff;
   logic [1:0]    reg7_ff;
   logic signed [DB-1:0] dx_in, dy_in;

   always_comb begin
      dx_in = qx6_ff - DB'(nxp6_ff);
      dy_in = qy6_ff - DB'(nyp6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (enable) begin
         v7_ff <= v6_ff;
      end
      if (enable) begin
         mdx7_ff <= dx_in[DB-1] ? DB'(-dx_in) : DB'(dx_in);
         mdy7_ff <= dy_in[DB-1] ? DB'(-dy_in) : DB'(dy_in);
         nxp7_ff <= nxp6_ff;
         nyp7_ff <= nyp6_ff;
         reg7_ff <= reg6_ff;
      end
   end

   // ---- stage 8: squares
   logic          v8_ff;
   logic [PB-1:0] sqx8_ff, sqy8_ff;
   logic signed [CB-1:0] nxp8_ff, nyp8_ff;
   logic [1:0]    reg8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (enable) begin
         v8_ff <= v7_ff;
      end
      if (enable) begin
         sqx8_ff <= PB'(mdx7_ff) * PB'(mdx7_ff);
         sqy8_ff <= PB'(mdy7_ff) * PB'(mdy7_ff);
         nxp8_ff <= nxp7_ff;
         nyp8_ff <= nyp7_ff;
         reg8_ff <= reg7_ff;
      end
   end

   // ---- stage 9: sum, scale to 32 fraction bits, saturate
   localparam int unsigned WB = SB + 64;
   logic          v9_ff;
   logic [DIST_BITS-1:0] d2_9_ff;
   logic signed [CB-1:0] nxp9_ff, nyp9_ff;
   logic [1:0]    reg9_ff;
   logic [WB-1:0] sum_in, scaled_in;

   always_comb begin
      sum_in = WB'(sqx8_ff) + WB'(sqy8_ff);
      if (SH >= 0) begin
         scaled_in = sum_in << SH;
      end else begin
         scaled_in = sum_in >> (-SH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (enable) begin
         v9_ff <= v8_ff;
      end
      if (enable) begin
         d2_9_ff <= (scaled_in[WB-1:DIST_BITS] != '0) ? '1
                                                      : scaled_in[DIST_BITS-1:0];
         nxp9_ff <= nxp8_ff;
         nyp9_ff <= nyp8_ff;
         reg9_ff <= reg8_ff;
      end
   end

   assign rsp_valid        = v9_ff;
   assign rsp_nearest_x    = IO_BITS'(nxp9_ff);
   assign rsp_nearest_y    = IO_BITS'(nyp9_ff);
   assign rsp_dist_squared = d2_9_ff;
   assign rsp_region       = reg9_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cps_checker.sv
// ----------------------------------------------------------------------------
// cps_port_checker
// port-level checks for the closest point on segment block
// ----------------------------------------------------------------------------
`default_nettype none

module cps_port_checker
   import cps_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [IO_BITS-1:0]   rsp_nearest_x,
   input wire logic [1:0]           rsp_region
);

   // region code never takes the unused value
   a_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_region != 2'd3)
      else $error("bad region code");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_x))
      else $error("result changed under stall");

   // input side is open whenever the output slot is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // a stall closes the input side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input open during stall");

endmodule

bind closest_point_on_segment_top cps_port_checker u_cps_port_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_nearest_x(rsp_nearest_x),
   .rsp_region   (rsp_region)
);

`default_nettype wire

>>> tb/cps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cps_checker
// watches both channels, predicts the closest point and compares results
// ----------------------------------------------------------------------------
`default_nettype none

module cps_checker
   import cps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic signed [IO_BITS-1:0] req_query_x,
   input  wire logic signed [IO_BITS-1:0] req_query_y,
   input  wire logic signed [IO_BITS-1:0] req_start_x,
   input  wire logic signed [IO_BITS-1:0] req_start_y,
   input  wire logic signed [IO_BITS-1:0] req_end_x,
   input  wire logic signed [IO_BITS-1:0] req_end_y,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic signed [IO_BITS-1:0] rsp_nearest_x,
   input  wire logic signed [IO_BITS-1:0] rsp_nearest_y,
   input  wire logic [DIST_BITS-1:0]      rsp_dist_squared,
   input  wire logic [1:0]                rsp_region,
   output int                             error_count,
   output int                             pending_count
);

   localparam int FRAC = FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic signed [IO_BITS-1:0] nearest_x;
      logic signed [IO_BITS-1:0] nearest_y;
      logic [DIST_BITS-1:0]      dist_squared;
      region_type                region;
   } nearest_point_type;

   nearest_point_type pending_points[$];

   // floor(diff * t / 2^32) added to the start coordinate
   function automatic logic signed [63:0] interpolate(logic signed [63:0] base,
                                                      logic signed [63:0] diff,
                                                      logic [31:0] t);
      logic signed [127:0] prod;
      prod = $signed({{64{diff[63]}}, diff}) * $signed({96'd0, t});
      return base + 64'(prod >>> 32);
   endfunction

   function automatic nearest_point_type project_point(
      logic signed [31:0] qx, logic signed [31:0] qy,
      logic signed [31:0] sx, logic signed [31:0] sy,
      logic signed [31:0] ex, logic signed [31:0] ey);
      nearest_point_type  res;
      logic signed [63:0] abx, aby, apx, apy, nx, ny, dx, dy;
      logic signed [127:0] dot, len2;
      logic [127:0]       rem, d2;
      logic [31:0]        t;
      abx = 64'(ex) - 64'(sx);
      aby = 64'(ey) - 64'(sy);
      apx = 64'(qx) - 64'(sx);
      apy = 64'(qy) - 64'(sy);
      dot = 128'(apx) * 128'(abx) + 128'(apy) * 128'(aby);
      len2 = 128'(abx) * 128'(abx) + 128'(aby) * 128'(aby);
      if (len2 == 0 || dot <= 0) begin
         nx = sx; ny = sy; res.region = REGION_START;
      end else if (dot >= len2) begin
         nx = ex; ny = ey; res.region = REGION_END;
      end else begin
         rem = dot;
         t = '0;
         for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= len2) begin
               rem = rem - len2;
               t[0] = 1'b1;
            end
         end
         nx = interpolate(sx, abx, t);
         ny = interpolate(sy, aby, t);
         res.region = REGION_INTERIOR;
      end
      dx = 64'(qx) - nx;
      dy = 64'(qy) - ny;
      d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      if (32 - 2 * FRAC >= 0) d2 = d2 << (32 - 2 * FRAC);
      else d2 = d2 >> (2 * FRAC - 32);
      res.dist_squared = (d2[127:64] != 0) ? '1 : d2[63:0];
      res.nearest_x = nx[31:0];
      res.nearest_y = ny[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      nearest_point_type exp_pt;
      if (reset) begin
         error_count <= 0;
         pending_points.delete();
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready)
            pending_points.push_back(project_point(req_query_x, req_query_y,
               req_start_x, req_start_y, req_end_x, req_end_y));
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               $error("unexpected result transaction");
               error_count <= error_count + 1;
            end else begin
               exp_pt = pending_points.pop_front();
               if (rsp_nearest_x !== exp_pt.nearest_x
                   || rsp_nearest_y !== exp_pt.nearest_y
                   || rsp_dist_squared !== exp_pt.dist_squared
                   || rsp_region !== exp_pt.region)
                  error_count <= error_count + 1;
               if (rsp_nearest_x !== exp_pt.nearest_x)
                  $error("nearest_x expected %0d actual %0d",
                         exp_pt.nearest_x, rsp_nearest_x);
               if (rsp_nearest_y !== exp_pt.nearest_y)
                  $error("nearest_y expected %0d actual %0d",
                         exp_pt.nearest_y, rsp_nearest_y);
               if (rsp_dist_squared !== exp_pt.dist_squared)
                  $error("dist_squared expected %h actual %h",
                         exp_pt.dist_squared, rsp_dist_squared);
               if (rsp_region !== exp_pt.region)
                  $error("region expected %0d actual %0d",
                         exp_pt.region, rsp_region);
            end
         end
         pending_count <= pending_points.size();
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the closest point on segment pipeline
// ----------------------------------------------------------------------------
// Directed corner queries, then random segments under random idling on both
// sides. The checker predicts each result; this module only drives and judges.
`default_nettype none

module tb_top;
   import cps_pkg::*;

   localparam int LATENCY   = 40;
   localparam int WATCH_MAX = 20000;
   localparam int N_RANDOM  = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   logic signed [IO_BITS-1:0] req_query_x = '0, req_query_y = '0;
   logic signed [IO_BITS-1:0] req_start_x = '0, req_start_y = '0;
   logic signed [IO_BITS-1:0] req_end_x = '0, req_end_y = '0;
   wire logic req_ready, rsp_valid;
   wire logic signed [IO_BITS-1:0] rsp_nearest_x, rsp_nearest_y;
   wire logic [DIST_BITS-1:0] rsp_dist_squared;
   wire logic [1:0] rsp_region;
   int error_count, pending_count;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;   // long receiver stall in progress

   always #10 clock = ~clock;

   closest_point_on_segment_top i_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_query_x, .req_query_y, .req_start_x, .req_start_y,
      .req_end_x, .req_end_y, .rsp_valid, .rsp_ready,
      .rsp_nearest_x, .rsp_nearest_y, .rsp_dist_squared, .rsp_region
   );

   cps_checker i_checker (
      .clock, .reset, .req_valid, .req_ready,
      .req_query_x, .req_query_y, .req_start_x, .req_start_y,
      .req_end_x, .req_end_y, .rsp_valid, .rsp_ready,
      .rsp_nearest_x, .rsp_nearest_y, .rsp_dist_squared, .rsp_region,
      .error_count, .pending_count
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // random coordinate: full range, small values or near the extremes
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   // offer one transaction and hold it until accepted; ready is sampled
   // mid-cycle so the accepting edge is the one that follows
   task automatic send_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] sx,
                             logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
      req_valid <= 1'b1;
      req_query_x <= qx; req_query_y <= qy;
      req_start_x <= sx; req_start_y <= sy;
      req_end_x <= ex; req_end_y <= ey;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // receiver idling, with one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         n = gap_length();
         rsp_ready <= (n == 0);
         @(posedge clock);
         if (n > 1) repeat (n - 1) @(posedge clock);
      end
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("** closest_point_on_segment_top: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [31:0] sx, sy, ex, ey, qx, qy;
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_query(0, 0, 0, 0, 0, 0);                              // zero-length
      send_query(32'h7fffffff, 32'h80000000, 5 << 16, 7 << 16,
                 5 << 16, 7 << 16);                              // zero-length far
      send_query(-(1 << 16), 0, 0, 0, 10 << 16, 0);              // before start
      send_query(0, 5 << 16, 0, 0, 10 << 16, 0);                 // exactly at start
      send_query(10 << 16, 3 << 16, 0, 0, 10 << 16, 0);          // exactly at end
      send_query(20 << 16, 0, 0, 0, 10 << 16, 0);                // past end
      send_query(3 << 16, 4 << 16, 0, 0, 10 << 16, 0);           // interior
      send_query(1 << 16, 1 << 16, 0, 0, -(7 << 16), 3 << 16);   // negative dir
      send_query(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h80000000);                    // extremes
      send_query(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff);                    // full diagonal
      send_query(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff);                    // distance overflow
      send_query(32'h00000001, 32'hffffffff, 32'hffffffff, 32'h00000001,
                 32'h00000003, 32'hfffffffd);                    // tiny steps
      send_query(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                 32'h55555555, 32'h55555555);
      send_query(2 << 16, 9 << 16, 1 << 16, 1 << 16, 3 << 16, 17 << 16);

      // sender pauses until the pipeline drains
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1'b1;
      for (int i = 0; i < 80; i++)
         send_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());

      // random part: mostly non-degenerate segments, some degenerate
      for (int i = 0; i < N_RANDOM; i++) begin
         sx = rand_coord(); sy = rand_coord();
         if ($urandom_range(0, 19) == 0) begin
            ex = sx; ey = sy;
         end else begin
            ex = rand_coord(); ey = rand_coord();
         end
         qx = rand_coord(); qy = rand_coord();
         send_query(qx, qy, sx, sy, ex, ey);
         if (i % 200 > 150) send_gap(0);
         else send_gap(gap_length());
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (pending_count != 0 && wait_cycles < 50 * WATCH_MAX);
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("** closest_point_on_segment_top: PASSED **");
      else
         $display("** closest_point_on_segment_top: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
